### hw/rtl/nspn_pkg.sv
// ----------------------------------------------------------------------------
// nspn_pkg
// Types, round constants and combined mix tables of the 256-bit nibble
// substitution-permutation network.
// ----------------------------------------------------------------------------
`default_nettype none

package nspn_pkg;

  localparam int unsigned Rows   = 8;
  localparam int unsigned Cols   = 8;
  localparam int unsigned RcRows = 12;
  localparam int unsigned RcW    = 4;
  localparam int unsigned WordW  = 64;

  typedef logic [Rows-1:0][31:0] grid_t;
  typedef logic [Rows-1:0][3:0]  nib_col_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_RUN,
    ST_HOLD
  } nspn_state_e;

  localparam logic [3:0] RC [RcRows][Rows] = '{
    '{4'h1, 4'h0, 4'h2, 4'h6, 4'he, 4'hf, 4'hd, 4'h9},
    '{4'h3, 4'h2, 4'h0, 4'h4, 4'hc, 4'hd, 4'hf, 4'hb},
    '{4'h7, 4'h6, 4'h4, 4'h0, 4'h8, 4'h9, 4'hb, 4'hf},
    '{4'he, 4'hf, 4'hd, 4'h9, 4'h1, 4'h0, 4'h2, 4'h6},
    '{4'hd, 4'hc, 4'he, 4'ha, 4'h2, 4'h3, 4'h1, 4'h5},
    '{4'hb, 4'ha, 4'h8, 4'hc, 4'h4, 4'h5, 4'h7, 4'h3},
    '{4'h6, 4'h7, 4'h5, 4'h1, 4'h9, 4'h8, 4'ha, 4'he},
    '{4'hc, 4'hd, 4'hf, 4'hb, 4'h3, 4'h2, 4'h0, 4'h4},
    '{4'h9, 4'h8, 4'ha, 4'he, 4'h6, 4'h7, 4'h5, 4'h1},
    '{4'h2, 4'h3, 4'h1, 4'h5, 4'hd, 4'hc, 4'he, 4'ha},
    '{4'h5, 4'h4, 4'h6, 4'h2, 4'ha, 4'hb, 4'h9, 4'hd},
    '{4'ha, 4'hb, 4'h9, 4'hd, 4'h5, 4'h4, 4'h6, 4'h2}
  };

  localparam logic [31:0] MIX [Rows][16] = '{
    '{32'hbf5c86f8, 32'ha9756b96, 32'hceb643e4, 32'h5dab3cd3,
      32'h1629ed6e, 32'h00000000, 32'h71eac51c, 32'h931d7f37,
      32'h67c32872, 32'hf4de5745, 32'hd89fae8a, 32'h3a6814a1,
      32'h85349259, 32'he2f7ba2b, 32'h2c41f9cf, 32'h4b82d1bd},
    '{32'h565ef4bc, 32'h7b7d93a5, 32'hb3b7e2c6, 32'hacafd85b,
      32'h2d236719, 32'h00000000, 32'he5e9167a, 32'h1f183a9d,
      32'hc8ca7163, 32'hd7d24bfe, 32'h9e9485df, 32'h6465a938,
      32'h323b5d84, 32'hfaf12ce7, 32'h4946ce21, 32'h818cbf42},
    '{32'hba3969b3, 32'haec2b2ac, 32'hc58d3dc8, 32'h5761c156,
      32'h14fbdb1f, 32'h00000000, 32'h7fb4547b, 32'h92ecfc9e,
      32'h6b4f8f64, 32'hf9a373fa, 32'hd176e6d7, 32'h3c2e4e32,
      32'h86172781, 32'hed58a8e5, 32'h28d5952d, 32'h439a1a49},
    '{32'hd33c3811, 32'h1cc5c644, 32'hf8868499, 32'h966b6322,
      32'hcff9fe55, 32'h00000000, 32'h2bbabc88, 32'h6eede7bb,
      32'he44342dd, 32'h8aaea566, 32'h377f7acc, 32'h722821ff,
      32'ha11419ee, 32'h45575b33, 32'hbdd1dfaa, 32'h59929d77},
    '{32'hb26f4579, 32'ha8b937f2, 32'hc13e2bad, 32'h54cd8ae1,
      32'h1ad6728b, 32'h00000000, 32'h73516ed4, 32'h95f3a14c,
      32'h69871c5f, 32'hfc74bd13, 32'hdbe85926, 32'h3d4a96be,
      32'h8f25d3c7, 32'he6a2cf98, 32'h279ce435, 32'h4e1bf86a},
    '{32'ha2539fc1, 32'he87c2954, 32'h51b8de69, 32'h74a61db2,
      32'h4a2fb695, 32'h00000000, 32'hf3eb41a8, 32'h251ec3db,
      32'hb9c4f73d, 32'h9cda34e6, 32'h1b9768fc, 32'hcd62ea8f,
      32'h6f31754e, 32'hd6f58273, 32'h874d5c1a, 32'h3e89ab27},
    '{32'h993846cb, 32'h22c63b5a, 32'hdd84236c, 32'h11638cb5,
      32'hbbfe7d91, 32'h00000000, 32'h44bc65a7, 32'hcce7afd9,
      32'hff421836, 32'h33a5b7ef, 32'h667a5efd, 32'hee219483,
      32'h7719d248, 32'h885bca7e, 32'h55dfe912, 32'haa9df124},
    '{32'heb643e47, 32'hdab3cd3f, 32'h7c32872a, 32'hf5c86f8e,
      32'h31d7f378, 32'h00000000, 32'h9756b96d, 32'h89fae8a4,
      32'ha6814a15, 32'h2f7ba2b1, 32'h4de57452, 32'h5349259b,
      32'hb82d1bdc, 32'h1eac51c9, 32'h629ed6e3, 32'hc41f9cf6}
  };

  function automatic logic [3:0] rc_cell(logic [RcW-1:0] idx, int unsigned row);
    logic [3:0] v;
    v = '0;
    if (int'(idx) < RcRows) begin
      v = RC[idx][row];
    end
    return v;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/nspn_if.sv
// ----------------------------------------------------------------------------
// nspn_in_if / nspn_out_if
// Valid/ready channels carrying state words into and result words out of
// the permutation unit.
// ----------------------------------------------------------------------------
`default_nettype none

interface nspn_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] state_word;

  modport source (output valid, output state_word, input ready);
  modport sink   (input valid, input state_word, output ready);
endinterface

interface nspn_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_word;
  logic        last_word;

  modport source (output valid, output result_word, output last_word, input ready);
  modport sink   (input valid, input result_word, input last_word, output ready);
endinterface

`default_nettype wire

### hw/rtl/nspn_lane.sv
// ----------------------------------------------------------------------------
// nspn_lane
// One output column of the combined S-box, row-shift and column-mix step:
// XOR of one table entry per row.
// ----------------------------------------------------------------------------
`default_nettype none

module nspn_lane (
  input  wire nspn_pkg::nib_col_t nib_i,
  output logic [31:0]             mix_o
);
  import nspn_pkg::*;

  always_comb begin
    mix_o = '0;
    for (int r = 0; r < Rows; r++) begin
      mix_o = mix_o ^ MIX[r][nib_i[r]];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/nspn_round.sv
// ----------------------------------------------------------------------------
// nspn_round
// One full round: constant addition into column 0, eight mix lanes in
// parallel, and the merge of lane columns back into the cell grid.
// ----------------------------------------------------------------------------
`default_nettype none

module nspn_round (
  input  wire nspn_pkg::grid_t             grid_i,
  input  wire logic [nspn_pkg::RcW-1:0]    rc_idx_i,
  output nspn_pkg::grid_t                  grid_o
);
  import nspn_pkg::*;

  grid_t               ark;
  nib_col_t [Cols-1:0] lane_nib;
  logic [Cols-1:0][31:0] lane_mix;

  always_comb begin
    ark = grid_i;
    for (int r = 0; r < Rows; r++) begin
      ark[r][3:0] = grid_i[r][3:0] ^ rc_cell(rc_idx_i, r);
    end
  end

  always_comb begin
    for (int c = 0; c < Cols; c++) begin
      for (int r = 0; r < Rows; r++) begin
        lane_nib[c][r] = ark[r][4*((r+c)%8) +: 4];
      end
    end
  end

  for (genvar c = 0; c < Cols; c++) begin : g_lane
    nspn_lane u_lane (
      .nib_i (lane_nib[c]),
      .mix_o (lane_mix[c])
    );
  end

  always_comb begin
    for (int r = 0; r < Rows; r++) begin
      for (int c = 0; c < Cols; c++) begin
        grid_o[r][4*c +: 4] = lane_mix[c][28-4*r +: 4];
      end
    end
  end

endmodule

`default_nettype wire

### hw/rtl/nibble_spn_permutation_256_unit.sv
// ----------------------------------------------------------------------------
// nibble_spn_permutation_256_unit
// 256-bit nibble SPN permutation over an 8x8 grid of 4-bit cells, loaded
// and emitted as four 64-bit words.
// ----------------------------------------------------------------------------
// Four state words are taken one per cycle; the fourth starts ROUNDS rounds,
// one round per cycle through eight parallel column lanes. The permuted state
// moves into an output buffer and drains as four words, the fourth flagged
// last, while the next four words load. The single round datapath sets the
// throughput: no new words are taken while the rounds run, or while the
// permuted state waits in ST_HOLD for the output buffer to drain.
`default_nettype none

module nibble_spn_permutation_256_unit #(
  parameter int unsigned ROUNDS = 12
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  nspn_in_if.sink    in_i,
  nspn_out_if.source out_o
);
  import nspn_pkg::*;

  nspn_state_e      state_q, state_d;
  logic [1:0]       load_cnt_q, load_cnt_d;
  logic [RcW-1:0]   round_q, round_d;
  grid_t            grid_q, grid_d;
  grid_t            round_out;
  grid_t            buf_q;
  logic [1:0]       out_cnt_q;
  logic             out_busy_q;
  logic             in_fire, out_fire, out_last, buf_free, buf_load;
  logic             last_round;

  assign in_i.ready = (state_q == ST_LOAD);
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_fire   = out_o.valid && out_o.ready;
  assign out_last   = (out_cnt_q == 2'd3);
  assign buf_free   = !out_busy_q || (out_fire && out_last);
  assign last_round = (round_q == RcW'(ROUNDS - 1));

  nspn_round u_round (
    .grid_i   (grid_q),
    .rc_idx_i (round_q),
    .grid_o   (round_out)
  );

  always_comb begin
    state_d     = state_q;
    load_cnt_d  = load_cnt_q;
    round_d     = round_q;
    grid_d      = grid_q;
    buf_load    = 1'b0;
    case (state_q)
      ST_LOAD: begin
        if (in_fire) begin
          grid_d[{load_cnt_q, 1'b0}] = in_i.state_word[31:0];
          grid_d[{load_cnt_q, 1'b1}] = in_i.state_word[63:32];
          load_cnt_d = load_cnt_q + 2'd1;
          if (load_cnt_q == 2'd3) begin
            state_d = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        grid_d = round_out;
        if (last_round) begin
          round_d = '0;
          if (buf_free) begin
            buf_load = 1'b1;
            state_d  = ST_LOAD;
          end else begin
            state_d  = ST_HOLD;
          end
        end else begin
          round_d = round_q + RcW'(1);
        end
      end
      ST_HOLD: begin
        if (buf_free) begin
          buf_load = 1'b1;
          state_d  = ST_LOAD;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_LOAD;
      load_cnt_q <= '0;
      round_q    <= '0;
      out_cnt_q  <= '0;
      out_busy_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      load_cnt_q <= load_cnt_d;
      round_q    <= round_d;
      if (buf_load) begin
        out_busy_q <= 1'b1;
        out_cnt_q  <= '0;
      end else if (out_fire) begin
        out_cnt_q <= out_cnt_q + 2'd1;
        if (out_last) begin
          out_busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    grid_q <= grid_d;
    if (buf_load) begin
      buf_q <= (state_q == ST_RUN) ? round_out : grid_q;
    end
  end

  assign out_o.valid       = out_busy_q;
  assign out_o.result_word = {buf_q[{out_cnt_q, 1'b1}], buf_q[{out_cnt_q, 1'b0}]};
  assign out_o.last_word   = out_last;

`ifndef SYNTHESIS
  a_round_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_RUN |-> round_q == '0)
    else $error("round counter not zero outside rounds");

  a_fourth_word_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && load_cnt_q == 2'd3 |=> state_q == ST_RUN)
    else $error("fourth word did not start rounds");

  a_drain_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && out_last && !buf_load |=> !out_o.valid)
    else $error("output still valid after last transfer");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    buf_load |-> !out_busy_q || (out_fire && out_last))
    else $error("output buffer overwritten before drained");
`endif

endmodule

`default_nettype wire

### bench/nibble_spn_permutation_256_unit_tb.sv
// ----------------------------------------------------------------------------
// nibble_spn_permutation_256_unit_tb
// Sends four-word state blocks through the permutation unit and compares
// each result word and its last flag against a grid model kept in the
// bench, with random idle cycles on the input and random stalls on the
// output.
// ----------------------------------------------------------------------------
module nibble_spn_permutation_256_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ROUNDS = 12;
  localparam int unsigned DrainCycles = ROUNDS + 16;

  typedef enum int unsigned {
    IDLE_NONE,
    IDLE_SOME,
    IDLE_HEAVY
  } idle_level_e;

  typedef struct packed {
    logic [nspn_pkg::WordW-1:0] word;
    logic                       last;
  } result_t;

  localparam logic [3:0] ROUND_KEYS [12][8] = '{
    '{4'h1, 4'h0, 4'h2, 4'h6, 4'he, 4'hf, 4'hd, 4'h9},
    '{4'h3, 4'h2, 4'h0, 4'h4, 4'hc, 4'hd, 4'hf, 4'hb},
    '{4'h7, 4'h6, 4'h4, 4'h0, 4'h8, 4'h9, 4'hb, 4'hf},
    '{4'he, 4'hf, 4'hd, 4'h9, 4'h1, 4'h0, 4'h2, 4'h6},
    '{4'hd, 4'hc, 4'he, 4'ha, 4'h2, 4'h3, 4'h1, 4'h5},
    '{4'hb, 4'ha, 4'h8, 4'hc, 4'h4, 4'h5, 4'h7, 4'h3},
    '{4'h6, 4'h7, 4'h5, 4'h1, 4'h9, 4'h8, 4'ha, 4'he},
    '{4'hc, 4'hd, 4'hf, 4'hb, 4'h3, 4'h2, 4'h0, 4'h4},
    '{4'h9, 4'h8, 4'ha, 4'he, 4'h6, 4'h7, 4'h5, 4'h1},
    '{4'h2, 4'h3, 4'h1, 4'h5, 4'hd, 4'hc, 4'he, 4'ha},
    '{4'h5, 4'h4, 4'h6, 4'h2, 4'ha, 4'hb, 4'h9, 4'hd},
    '{4'ha, 4'hb, 4'h9, 4'hd, 4'h5, 4'h4, 4'h6, 4'h2}
  };

  localparam logic [31:0] MIX_LUT [8][16] = '{
    '{32'hbf5c86f8, 32'ha9756b96, 32'hceb643e4, 32'h5dab3cd3,
      32'h1629ed6e, 32'h00000000, 32'h71eac51c, 32'h931d7f37,
      32'h67c32872, 32'hf4de5745, 32'hd89fae8a, 32'h3a6814a1,
      32'h85349259, 32'he2f7ba2b, 32'h2c41f9cf, 32'h4b82d1bd},
    '{32'h565ef4bc, 32'h7b7d93a5, 32'hb3b7e2c6, 32'hacafd85b,
      32'h2d236719, 32'h00000000, 32'he5e9167a, 32'h1f183a9d,
      32'hc8ca7163, 32'hd7d24bfe, 32'h9e9485df, 32'h6465a938,
      32'h323b5d84, 32'hfaf12ce7, 32'h4946ce21, 32'h818cbf42},
    '{32'hba3969b3, 32'haec2b2ac, 32'hc58d3dc8, 32'h5761c156,
      32'h14fbdb1f, 32'h00000000, 32'h7fb4547b, 32'h92ecfc9e,
      32'h6b4f8f64, 32'hf9a373fa, 32'hd176e6d7, 32'h3c2e4e32,
      32'h86172781, 32'hed58a8e5, 32'h28d5952d, 32'h439a1a49},
    '{32'hd33c3811, 32'h1cc5c644, 32'hf8868499, 32'h966b6322,
      32'hcff9fe55, 32'h00000000, 32'h2bbabc88, 32'h6eede7bb,
      32'he44342dd, 32'h8aaea566, 32'h377f7acc, 32'h722821ff,
      32'ha11419ee, 32'h45575b33, 32'hbdd1dfaa, 32'h59929d77},
    '{32'hb26f4579, 32'ha8b937f2, 32'hc13e2bad, 32'h54cd8ae1,
      32'h1ad6728b, 32'h00000000, 32'h73516ed4, 32'h95f3a14c,
      32'h69871c5f, 32'hfc74bd13, 32'hdbe85926, 32'h3d4a96be,
      32'h8f25d3c7, 32'he6a2cf98, 32'h279ce435, 32'h4e1bf86a},
    '{32'ha2539fc1, 32'he87c2954, 32'h51b8de69, 32'h74a61db2,
      32'h4a2fb695, 32'h00000000, 32'hf3eb41a8, 32'h251ec3db,
      32'hb9c4f73d, 32'h9cda34e6, 32'h1b9768fc, 32'hcd62ea8f,
      32'h6f31754e, 32'hd6f58273, 32'h874d5c1a, 32'h3e89ab27},
    '{32'h993846cb, 32'h22c63b5a, 32'hdd84236c, 32'h11638cb5,
      32'hbbfe7d91, 32'h00000000, 32'h44bc65a7, 32'hcce7afd9,
      32'hff421836, 32'h33a5b7ef, 32'h667a5efd, 32'hee219483,
      32'h7719d248, 32'h885bca7e, 32'h55dfe912, 32'haa9df124},
    '{32'heb643e47, 32'hdab3cd3f, 32'h7c32872a, 32'hf5c86f8e,
      32'h31d7f378, 32'h00000000, 32'h9756b96d, 32'h89fae8a4,
      32'ha6814a15, 32'h2f7ba2b1, 32'h4de57452, 32'h5349259b,
      32'hb82d1bdc, 32'h1eac51c9, 32'h629ed6e3, 32'hc41f9cf6}
  };

  logic clk_i;
  logic rst_ni;

  nspn_in_if  state_in ();
  nspn_out_if result_out ();

  nibble_spn_permutation_256_unit #(
    .ROUNDS(ROUNDS)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (state_in),
    .out_o (result_out)
  );

  logic [3:0]  cell_model [64];
  int unsigned words_held;
  result_t     pending_results [$];
  int unsigned mismatches;
  idle_level_e send_idles;
  idle_level_e drain_stalls;
  int unsigned stall_left;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #3_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic int unsigned pick_pause(idle_level_e level);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    case (level)
      IDLE_SOME: begin
        if (roll < 65) return 0;
        if (roll < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
      end
      IDLE_HEAVY: begin
        if (roll < 30) return 0;
        if (roll < 70) return $urandom_range(1, 4);
        return $urandom_range(10, 40);
      end
      default: return 0;
    endcase
  endfunction

  function automatic void permute_grid();
    logic [3:0]  prev [64];
    logic [31:0] column;
    for (int unsigned rnd = 0; rnd < ROUNDS; rnd++) begin
      for (int unsigned r = 0; r < 8; r++) begin
        cell_model[r*8] = cell_model[r*8] ^ ROUND_KEYS[rnd % 12][r];
      end
      prev = cell_model;
      for (int unsigned c = 0; c < 8; c++) begin
        column = '0;
        for (int unsigned r = 0; r < 8; r++) begin
          column ^= MIX_LUT[r][prev[r*8 + ((r + c) & 7)]];
        end
        for (int unsigned r = 0; r < 8; r++) begin
          cell_model[r*8 + c] = column[28 - 4*r +: 4];
        end
      end
    end
  endfunction

  function automatic void absorb_state_word(logic [63:0] word);
    result_t res;
    for (int unsigned i = 0; i < 16; i++) begin
      cell_model[words_held*16 + i] = word[4*i +: 4];
    end
    if (words_held < 3) begin
      words_held++;
      return;
    end
    words_held = 0;
    permute_grid();
    for (int unsigned j = 0; j < 4; j++) begin
      for (int unsigned i = 0; i < 16; i++) begin
        res.word[4*i +: 4] = cell_model[j*16 + i];
      end
      res.last = (j == 3);
      pending_results.push_back(res);
    end
  endfunction

  task automatic send_word(input logic [63:0] word);
    int unsigned gap;
    gap = pick_pause(send_idles);
    if (gap != 0) begin
      state_in.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    state_in.valid      <= 1'b1;
    state_in.state_word <= word;
    @(posedge clk_i);
    while (!state_in.ready) @(posedge clk_i);
    absorb_state_word(word);
  endtask

  task automatic send_block(input logic [63:0] w0, input logic [63:0] w1,
                            input logic [63:0] w2, input logic [63:0] w3);
    send_word(w0);
    send_word(w1);
    send_word(w2);
    send_word(w3);
  endtask

  function automatic logic [63:0] random_word();
    logic [63:0] w;
    logic [3:0]  nib;
    case ($urandom_range(0, 4))
      0: w = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
      1: w = {$urandom, $urandom} | {$urandom, $urandom} | {$urandom, $urandom};
      2: begin
        nib = 4'($urandom_range(0, 15));
        w   = {16{nib}};
        w[4*$urandom_range(0, 15) +: 4] = 4'($urandom_range(0, 15));
      end
      default: w = {$urandom, $urandom};
    endcase
    return w;
  endfunction

  task automatic check_result();
    result_t want;
    if (pending_results.size() == 0) begin
      $error("result_word: expected none, actual %h", result_out.result_word);
      mismatches++;
      return;
    end
    want = pending_results.pop_front();
    if (result_out.result_word !== want.word) begin
      $error("result_word: expected %h, actual %h", want.word, result_out.result_word);
      mismatches++;
    end
    if (result_out.last_word !== want.last) begin
      $error("last_word: expected %b, actual %b", want.last, result_out.last_word);
      mismatches++;
    end
  endtask

  initial begin
    result_out.ready <= 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && result_out.valid && result_out.ready) begin
        check_result();
      end
      if (stall_left != 0) begin
        stall_left--;
        result_out.ready <= 1'b0;
      end else begin
        result_out.ready <= 1'b1;
        stall_left = pick_pause(drain_stalls);
      end
    end
  end

  task automatic test_zero_state();
    send_block('0, '0, '0, '0);
  endtask

  task automatic test_ones_state();
    send_block('1, '1, '1, '1);
  endtask

  task automatic test_alternating();
    send_block(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa,
               64'h0f0f_0f0f_0f0f_0f0f, 64'hf0f0_f0f0_f0f0_f0f0);
  endtask

  task automatic test_single_bits();
    send_block(64'h0000_0000_0000_0001, 64'h8000_0000_0000_0000,
               64'h0000_0001_0000_0000, 64'h0000_0000_8000_0000);
  endtask

  task automatic test_nibble_order();
    send_block(64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210,
               64'hffff_ffff_0000_0000, 64'h0000_0000_ffff_ffff);
  endtask

  task automatic test_random_blocks(input int unsigned blocks);
    send_idles   = IDLE_SOME;
    drain_stalls = IDLE_SOME;
    for (int unsigned b = 0; b < blocks; b++) begin
      send_block(random_word(), random_word(), random_word(), random_word());
    end
  endtask

  task automatic test_back_to_back(input int unsigned blocks);
    send_idles   = IDLE_NONE;
    drain_stalls = IDLE_NONE;
    for (int unsigned b = 0; b < blocks; b++) begin
      send_block(random_word(), random_word(), random_word(), random_word());
    end
  endtask

  task automatic test_slow_drain(input int unsigned blocks);
    send_idles   = IDLE_NONE;
    drain_stalls = IDLE_HEAVY;
    for (int unsigned b = 0; b < blocks; b++) begin
      send_block(random_word(), random_word(), random_word(), random_word());
    end
    send_idles   = IDLE_HEAVY;
    drain_stalls = IDLE_NONE;
    for (int unsigned b = 0; b < blocks; b++) begin
      send_block(random_word(), random_word(), random_word(), random_word());
    end
  endtask

  initial begin
    rst_ni              <= 1'b0;
    state_in.valid      <= 1'b0;
    state_in.state_word <= '0;
    words_held   = 0;
    mismatches   = 0;
    send_idles   = IDLE_SOME;
    drain_stalls = IDLE_SOME;
    foreach (cell_model[i]) cell_model[i] = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_zero_state();
    test_ones_state();
    test_alternating();
    test_single_bits();
    test_nibble_order();
    test_random_blocks(76);
    test_back_to_back(12);
    test_slow_drain(6);

    state_in.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/nspn_pkg.sv
hw/rtl/nspn_if.sv
hw/rtl/nspn_lane.sv
hw/rtl/nspn_round.sv
hw/rtl/nibble_spn_permutation_256_unit.sv
bench/nibble_spn_permutation_256_unit_tb.sv
